FILE: rtl/oiset_pkg.sv
`default_nettype none

package oiset_pkg;

  // command codes carried on in_tuser
  localparam int CMD_W = 3;
  localparam logic [CMD_W-1:0] CMD_INSERT   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CONTAINS = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SUCC     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PRED     = 3'd4;
  localparam logic [CMD_W-1:0] CMD_MIN      = 3'd5;
  localparam logic [CMD_W-1:0] CMD_MAX      = 3'd6;

  // universe register
  localparam int CFG_W     = 4;
  localparam int CFG_RESET = 12;

  // bit scan control
  typedef struct packed {
    logic down;     // search towards bit 0
    logic bounded;  // apply the start-bit mask
  } scan_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/oiset_scan.sv
`default_nettype none

// masked priority encoder, lowest or highest set bit
module oiset_scan import oiset_pkg::*; #(
  parameter int WORD_BITS = 64
) (
  input  wire logic [WORD_BITS-1:0]         word,
  input  wire logic [$clog2(WORD_BITS)-1:0] from_bit,
  input  wire scan_ctl_t                    ctl,
  output logic                              hit,
  output logic [$clog2(WORD_BITS)-1:0]      idx
);

  localparam int BIT_W = $clog2(WORD_BITS);

  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] m;
  logic [WORD_BITS-1:0] mo;
  logic [WORD_BITS-1:0] oh;
  logic [BIT_W-1:0]     enc;

  always_comb begin
    if (!ctl.bounded) begin
      mask = '1;
    end else if (ctl.down) begin
      mask = {WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - from_bit);
    end else begin
      mask = {WORD_BITS{1'b1}} << from_bit;
    end
    m = word & mask;
    // reverse for a downward search so both ways take the lowest bit
    for (int i = 0; i < WORD_BITS; i++) begin
      mo[i] = ctl.down ? m[WORD_BITS-1-i] : m[i];
    end
    oh  = mo & (~mo + WORD_BITS'(1));
    enc = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (oh[i]) begin
        enc = enc | BIT_W'(i);
      end
    end
  end

  assign hit = |m;
  assign idx = ctl.down ? BIT_W'(WORD_BITS - 1) - enc : enc;

endmodule

`default_nettype wire

FILE: rtl/oiset_cdiv.sv
`default_nettype none

// divide by a constant through a reciprocal; quotient registered
module oiset_cdiv #(
  parameter int X_BITS  = 12,
  parameter int DIVISOR = 64
) (
  input  wire logic                       clk,
  input  wire logic [X_BITS-1:0]          x,
  output logic [X_BITS-1:0]               q,
  output logic [$clog2(DIVISOR)-1:0]      r
);

  localparam int RB    = $clog2(DIVISOR);
  localparam int S     = X_BITS + RB;
  localparam int RECIP = ((1 << S) + DIVISOR - 1) / DIVISOR;
  localparam int PW    = X_BITS + S + 1;

  logic [PW-1:0]     prod;
  logic [X_BITS-1:0] q_r;
  logic [X_BITS-1:0] x_r;

  assign prod = PW'(x) * PW'(RECIP);

  always_ff @(posedge clk) begin
    q_r <= prod[S +: X_BITS];
    x_r <= x;
  end

  assign q = q_r;
  assign r = RB'(x_r - X_BITS'(int'(q_r) * DIVISOR));

endmodule

`default_nettype wire

FILE: rtl/ordered_integer_set.sv
`default_nettype none

// channel  dir  handshake               payload
// in_      in   in_tvalid/in_tready     tuser: cmd; tdata: key
// out_     out  out_tvalid/out_tready   tuser: found; tdata: result_key, element_count
// cfg_     in   cfg_valid/cfg_ready     cfg_data: universe_log2
//
// One item at a time, one result per item. Rejected items (key outside the universe,
// successor of the top key, predecessor of 0, unused command) go straight to the finish
// step; searches walk at most SUM_WORDS-1 extra summary words. Each memory has a single
// read port, and the one bit scan unit is shared. After reset and after every cfg
// transfer a clearing pass over all NUM_WORDS words (64 at default) zeroes both
// bitmaps; in_tready stays low meanwhile. A result waiting on out_tready does not stop
// the next input transfer; the sequencer only holds in its finish step until the
// output register is free.
module ordered_integer_set import oiset_pkg::*; #(
  parameter int KEY_BITS  = 12,
  parameter int WORD_BITS = 64
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [((KEY_BITS+7)/8)*8-1:0]      in_tdata,   // key
  input  wire logic [CMD_W-1:0]                   in_tuser,   // cmd
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [((2*KEY_BITS+8)/8)*8-1:0]         out_tdata,  // result_key, element_count
  output logic                                    out_tuser,  // found
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [CFG_W-1:0]                   cfg_data    // universe_log2
);

  localparam int NUM_WORDS = ((1 << KEY_BITS) + WORD_BITS - 1) / WORD_BITS;
  localparam int SUM_WORDS = (NUM_WORDS + WORD_BITS - 1) / WORD_BITS;
  localparam int WIDX      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int SIDX      = (SUM_WORDS > 1) ? $clog2(SUM_WORDS) : 1;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int ULW       = $clog2(KEY_BITS + 1);
  localparam int ULOG_INIT = (CFG_RESET > KEY_BITS) ? KEY_BITS : CFG_RESET;
  localparam int OUT_DW    = ((2*KEY_BITS+8)/8)*8;

  // sequencer states
  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DIV   = 4'd2;  // split key into word and bit
  localparam logic [3:0] S_RD    = 4'd3;  // read presence word
  localparam logic [3:0] S_EVAL  = 4'd4;  // test, update or scan the word
  localparam logic [3:0] S_SDIV  = 4'd5;  // split word index for the summary
  localparam logic [3:0] S_SRD   = 4'd6;  // read summary word
  localparam logic [3:0] S_SEVAL = 4'd7;  // update or walk the summary
  localparam logic [3:0] S_WEVAL = 4'd8;  // scan the word the summary pointed at
  localparam logic [3:0] S_FIN   = 4'd9;

  logic [3:0]          state_r, state_nxt;
  logic [WIDX-1:0]     clr_r, clr_nxt;
  logic [ULW-1:0]      ulog_r, ulog_nxt;
  logic [KEY_BITS:0]   count_r, count_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic [CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [KEY_BITS-1:0] pos_r, pos_nxt;
  logic [WIDX-1:0]     wi_r, wi_nxt;
  logic [BIT_W-1:0]    bi_r, bi_nxt;
  logic [WIDX-1:0]     spos_r, spos_nxt;
  logic [SIDX-1:0]     sidx_r, sidx_nxt;
  logic [BIT_W-1:0]    sbit_r, sbit_nxt;
  logic                sbnd_r, sbnd_nxt;
  logic                res_found_r, res_found_nxt;
  logic [KEY_BITS-1:0] res_key_r, res_key_nxt;
  logic                out_found_r, out_found_nxt;
  logic [KEY_BITS-1:0] out_key_r, out_key_nxt;
  logic [KEY_BITS:0]   out_count_r, out_count_nxt;

  // bitmaps
  logic [WORD_BITS-1:0] pmem [NUM_WORDS];
  logic [WORD_BITS-1:0] smem [SUM_WORDS];
  logic [WORD_BITS-1:0] prd_r, srd_r;
  logic                 pwe, swe;
  logic [WIDX-1:0]      pwa, pra;
  logic [SIDX-1:0]      swa, sra;
  logic [WORD_BITS-1:0] pwd, swd;

  logic [KEY_BITS-1:0]  kq;
  logic [BIT_W-1:0]     kr;
  logic [WIDX-1:0]      wq;
  logic [BIT_W-1:0]     wr;

  logic [WORD_BITS-1:0] sc_word;
  logic [BIT_W-1:0]     sc_from;
  scan_ctl_t            sc_ctl;
  logic                 sc_hit;
  logic [BIT_W-1:0]     sc_idx;

  logic                 in_acc, cfg_acc;
  logic [KEY_BITS-1:0]  key_in;
  logic [KEY_BITS:0]    key_inc;
  logic                 in_rng, succ_ok;
  logic [ULW-1:0]       ulog_cfg;
  logic [WORD_BITS-1:0] poh, soh;
  logic [WIDX-1:0]      hit_w;

  function automatic logic [KEY_BITS-1:0] key_of(input logic [WIDX-1:0] w,
                                                 input logic [BIT_W-1:0] b);
    return KEY_BITS'(int'(w) * WORD_BITS + int'(b));
  endfunction

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign cfg_acc   = cfg_valid & cfg_ready;
  assign key_in    = in_tdata[KEY_BITS-1:0];
  assign key_inc   = {1'b0, key_in} + (KEY_BITS+1)'(1);
  assign in_rng    = (key_in >> ulog_r) == '0;
  assign succ_ok   = (key_inc >> ulog_r) == '0;

  // out-of-range register values are pulled into 1..KEY_BITS
  always_comb begin
    if (cfg_data == '0) begin
      ulog_cfg = ULW'(1);
    end else if (32'(cfg_data) > KEY_BITS) begin
      ulog_cfg = ULW'(KEY_BITS);
    end else begin
      ulog_cfg = ULW'(cfg_data);
    end
  end

  oiset_cdiv #(.X_BITS(KEY_BITS), .DIVISOR(WORD_BITS)) u_kdiv (
    .clk (clk),
    .x   (pos_r),
    .q   (kq),
    .r   (kr)
  );

  oiset_cdiv #(.X_BITS(WIDX), .DIVISOR(WORD_BITS)) u_wdiv (
    .clk (clk),
    .x   (spos_r),
    .q   (wq),
    .r   (wr)
  );

  // the one scan unit serves presence and summary words alike
  assign sc_word        = (state_r == S_SEVAL) ? srd_r  : prd_r;
  assign sc_from        = (state_r == S_SEVAL) ? sbit_r : bi_r;
  assign sc_ctl.bounded = (state_r == S_EVAL) || ((state_r == S_SEVAL) && sbnd_r);
  assign sc_ctl.down    = (cmd_r == CMD_PRED) || (cmd_r == CMD_MAX);

  oiset_scan #(.WORD_BITS(WORD_BITS)) u_scan (
    .word     (sc_word),
    .from_bit (sc_from),
    .ctl      (sc_ctl),
    .hit      (sc_hit),
    .idx      (sc_idx)
  );

  assign poh   = WORD_BITS'(1) << bi_r;
  assign soh   = WORD_BITS'(1) << sbit_r;
  assign hit_w = WIDX'(int'(sidx_r) * WORD_BITS + int'(sc_idx));

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    ulog_nxt      = ulog_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    cmd_nxt       = cmd_r;
    pos_nxt       = pos_r;
    wi_nxt        = wi_r;
    bi_nxt        = bi_r;
    spos_nxt      = spos_r;
    sidx_nxt      = sidx_r;
    sbit_nxt      = sbit_r;
    sbnd_nxt      = sbnd_r;
    res_found_nxt = res_found_r;
    res_key_nxt   = res_key_r;
    out_found_nxt = out_found_r;
    out_key_nxt   = out_key_r;
    out_count_nxt = out_count_r;
    pwe = 1'b0;
    pwa = wi_r;
    pwd = '0;
    pra = wi_r;
    swe = 1'b0;
    swa = sidx_r;
    swd = '0;
    sra = sidx_r;

    case (state_r)
      S_CLEAR: begin
        pwe = 1'b1;
        pwa = clr_r;
        swa = clr_r[SIDX-1:0];
        swe = 32'(clr_r) < SUM_WORDS;
        if (clr_r == WIDX'(NUM_WORDS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + WIDX'(1);
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt       = in_tuser;
          res_found_nxt = 1'b0;
          res_key_nxt   = '0;
          pos_nxt       = key_in;
          case (in_tuser)
            CMD_INSERT, CMD_REMOVE, CMD_CONTAINS: begin
              state_nxt = in_rng ? S_DIV : S_FIN;
            end
            CMD_SUCC: begin
              pos_nxt   = key_inc[KEY_BITS-1:0];
              state_nxt = succ_ok ? S_DIV : S_FIN;
            end
            CMD_PRED: begin
              pos_nxt   = key_in - KEY_BITS'(1);
              state_nxt = (key_in != '0) ? S_DIV : S_FIN;
            end
            CMD_MIN: begin
              pos_nxt   = '0;
              state_nxt = S_DIV;
            end
            CMD_MAX: begin
              pos_nxt   = '1;
              state_nxt = S_DIV;
            end
            default: begin
              state_nxt = S_FIN;
            end
          endcase
        end
      end
      S_DIV: begin
        state_nxt = S_RD;
      end
      S_RD: begin
        pra       = kq[WIDX-1:0];
        wi_nxt    = kq[WIDX-1:0];
        bi_nxt    = kr;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        spos_nxt  = wi_r;
        state_nxt = S_FIN;
        case (cmd_r)
          CMD_INSERT: begin
            if (!prd_r[bi_r]) begin
              pwe           = 1'b1;
              pwd           = prd_r | poh;
              count_nxt     = count_r + (KEY_BITS+1)'(1);
              res_found_nxt = 1'b1;
              state_nxt     = S_SDIV;
            end
          end
          CMD_REMOVE: begin
            pwd = prd_r & ~poh;
            if (prd_r[bi_r]) begin
              pwe           = 1'b1;
              count_nxt     = count_r - (KEY_BITS+1)'(1);
              res_found_nxt = 1'b1;
              // word emptied: drop its summary bit
              if (pwd == '0) begin
                state_nxt = S_SDIV;
              end
            end
          end
          CMD_CONTAINS: begin
            res_found_nxt = prd_r[bi_r];
          end
          default: begin
            if (sc_hit) begin
              res_found_nxt = 1'b1;
              res_key_nxt   = key_of(wi_r, sc_idx);
            end else if (sc_ctl.down) begin
              if (wi_r != '0) begin
                spos_nxt  = wi_r - WIDX'(1);
                state_nxt = S_SDIV;
              end
            end else begin
              if (wi_r != WIDX'(NUM_WORDS - 1)) begin
                spos_nxt  = wi_r + WIDX'(1);
                state_nxt = S_SDIV;
              end
            end
          end
        endcase
      end
      S_SDIV: begin
        state_nxt = S_SRD;
      end
      S_SRD: begin
        sra       = wq[SIDX-1:0];
        sidx_nxt  = wq[SIDX-1:0];
        sbit_nxt  = wr;
        sbnd_nxt  = 1'b1;
        state_nxt = S_SEVAL;
      end
      S_SEVAL: begin
        state_nxt = S_FIN;
        case (cmd_r)
          CMD_INSERT: begin
            swe = 1'b1;
            swd = srd_r | soh;
          end
          CMD_REMOVE: begin
            swe = 1'b1;
            swd = srd_r & ~soh;
          end
          default: begin
            if (sc_hit) begin
              wi_nxt    = hit_w;
              pra       = hit_w;
              state_nxt = S_WEVAL;
            end else if (sc_ctl.down) begin
              // walk down one summary word, read lands next cycle
              if (sidx_r != '0) begin
                sra       = sidx_r - SIDX'(1);
                sidx_nxt  = sra;
                sbnd_nxt  = 1'b0;
                state_nxt = S_SEVAL;
              end
            end else begin
              if (sidx_r != SIDX'(SUM_WORDS - 1)) begin
                sra       = sidx_r + SIDX'(1);
                sidx_nxt  = sra;
                sbnd_nxt  = 1'b0;
                state_nxt = S_SEVAL;
              end
            end
          end
        endcase
      end
      S_WEVAL: begin
        res_found_nxt = sc_hit;
        res_key_nxt   = sc_hit ? key_of(wi_r, sc_idx) : '0;
        state_nxt     = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_key_nxt   = res_key_r;
          out_count_nxt = count_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
        clr_nxt   = '0;
      end
    endcase

    // universe write empties the set
    if (cfg_acc) begin
      ulog_nxt  = ulog_cfg;
      count_nxt = '0;
      clr_nxt   = '0;
      state_nxt = S_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      ulog_r      <= ULW'(ULOG_INIT);
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      ulog_r      <= ulog_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    pos_r       <= pos_nxt;
    wi_r        <= wi_nxt;
    bi_r        <= bi_nxt;
    spos_r      <= spos_nxt;
    sidx_r      <= sidx_nxt;
    sbit_r      <= sbit_nxt;
    sbnd_r      <= sbnd_nxt;
    res_found_r <= res_found_nxt;
    res_key_r   <= res_key_nxt;
    out_found_r <= out_found_nxt;
    out_key_r   <= out_key_nxt;
    out_count_r <= out_count_nxt;
  end

  always_ff @(posedge clk) begin
    if (pwe) begin
      pmem[pwa] <= pwd;
    end
    prd_r <= pmem[pra];
  end

  always_ff @(posedge clk) begin
    if (swe) begin
      smem[swa] <= swd;
    end
    srd_r <= smem[sra];
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = OUT_DW'({out_count_r, out_key_r});

endmodule

`default_nettype wire

FILE: rtl/oiset_chk.sv
`default_nettype none

module oiset_chk import oiset_pkg::*; #(
  parameter int KEY_BITS = 12
) (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_tvalid,
  input wire logic                           in_tready,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [((2*KEY_BITS+8)/8)*8-1:0] out_tdata,
  input wire logic                           out_tuser,
  input wire logic                           cfg_valid,
  input wire logic                           cfg_ready
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // no answer key without found
  a_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[KEY_BITS-1:0] == '0)
    else $error("result key set with found low");

  // count never beyond 2**KEY_BITS, the largest universe
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2*KEY_BITS:KEY_BITS] <= {1'b1, {KEY_BITS{1'b0}}})
    else $error("element count out of range");

  // one item at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while busy");

  // universe write starts a clearing pass
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> !in_tready)
    else $error("input open during clearing pass");

endmodule

bind ordered_integer_set oiset_chk #(.KEY_BITS(KEY_BITS)) u_oiset_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready)
);

`default_nettype wire
